>>> design/acsp_pkg.sv
// Package with the shared types and constants of the CSI sequence parser.
`default_nettype none
package acsp_pkg;

  localparam int unsigned MaxParamsDefault = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned CountExtW = 6;

  localparam logic [7:0] ByteEsc = 8'h1B;
  localparam logic [7:0] ByteLBracket = 8'h5B;
  localparam logic [7:0] ByteQMark = 8'h3F;
  localparam logic [7:0] ByteSemi = 8'h3B;
  localparam logic [7:0] ByteZero = 8'h30;
  localparam logic [7:0] ByteNine = 8'h39;

  localparam logic [19:0] ValueCap = 20'h0FFFF;
  localparam logic [CountExtW-1:0] RunLimit = CountExtW'(8);
  localparam logic [CountExtW-1:0] TotalCap = CountExtW'(15);

  typedef enum logic [1:0] {
    MODE_GROUND = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    OP_CHAR  = 2'd0,
    OP_STORE = 2'd1,
    OP_RUN   = 2'd2
  } op_e;

  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_RUN  = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  code;
    logic        priv;
    logic        store_en;
    logic [15:0] value;
    logic [3:0]  total;
    logic [3:0]  count;
  } cmd_t;

endpackage
`default_nettype wire

>>> design/acsp_front.sv
// Front end: tracks the parser mode, collects parameters and issues commands.
`default_nettype none
module acsp_front #(
  parameter int unsigned MAX_PARAMS = acsp_pkg::MaxParamsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  output logic               cmd_push_o,
  output acsp_pkg::cmd_t     cmd_o
);
  import acsp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PARAMS + 1);

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] count_q, count_d;
  logic [15:0]     pend_q, pend_d;
  logic            priv_q, priv_d;

  logic                 is_digit;
  logic                 room;
  logic [19:0]          acc;
  logic [CntW-1:0]      count_fin;
  logic [CountExtW-1:0] count_ext;

  assign is_digit = (in_byte_i >= ByteZero) && (in_byte_i <= ByteNine);
  assign room = count_q < CntW'(MAX_PARAMS);
  assign acc = ({4'b0, pend_q} << 3) + ({4'b0, pend_q} << 1) + {16'b0, in_byte_i[3:0]};
  assign count_fin = room ? CntW'(count_q + 1'b1) : count_q;
  assign count_ext = CountExtW'(count_fin);

  always_comb begin
    mode_d = mode_q;
    if (accept_i) begin
      case (mode_q)
        MODE_ESC: begin
          mode_d = (in_byte_i == ByteLBracket) ? MODE_CSI : MODE_GROUND;
        end
        MODE_CSI: begin
          if (!(in_byte_i == ByteQMark || is_digit || in_byte_i == ByteSemi)) begin
            mode_d = MODE_GROUND;
          end
        end
        default: begin
          mode_d = (in_byte_i == ByteEsc) ? MODE_ESC : MODE_GROUND;
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    pend_d = pend_q;
    priv_d = priv_q;
    cmd_push_o = 1'b0;
    cmd_o = '0;
    cmd_o.op = OP_CHAR;
    cmd_o.code = in_byte_i;
    cmd_o.value = pend_q;
    if (accept_i) begin
      case (mode_q)
        MODE_ESC: begin
          if (in_byte_i == ByteLBracket) begin
            count_d = '0;
            pend_d = '0;
            priv_d = 1'b0;
          end
        end
        MODE_CSI: begin
          if (in_byte_i == ByteQMark) begin
            priv_d = 1'b1;
          end else if (is_digit) begin
            pend_d = (acc > ValueCap) ? 16'hFFFF : acc[15:0];
          end else if (in_byte_i == ByteSemi) begin
            if (room) begin
              cmd_push_o = 1'b1;
              cmd_o.op = OP_STORE;
              cmd_o.store_en = 1'b1;
              count_d = CntW'(count_q + 1'b1);
              pend_d = '0;
            end
          end else begin
            cmd_push_o = 1'b1;
            cmd_o.op = OP_RUN;
            cmd_o.priv = priv_q;
            cmd_o.store_en = room;
            cmd_o.total = (count_ext > TotalCap) ? 4'd15 : count_ext[3:0];
            cmd_o.count = (count_ext > RunLimit) ? 4'd8 : count_ext[3:0];
            count_d = count_fin;
            pend_d = '0;
          end
        end
        default: begin
          if (in_byte_i != ByteEsc) begin
            cmd_push_o = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GROUND;
      count_q <= '0;
      pend_q <= '0;
      priv_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      count_q <= count_d;
      pend_q <= pend_d;
      priv_q <= priv_d;
    end
  end

endmodule
`default_nettype wire

>>> design/acsp_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none
module acsp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  acsp_pkg::cmd_t      cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output acsp_pkg::cmd_t      cmd_o,
  output logic                empty_o
);
  import acsp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned LvlW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [LvlW-1:0] lvl_q;
  logic            do_push, do_pop;

  assign full_o = lvl_q == LvlW'(QueueDepth);
  assign empty_o = lvl_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      lvl_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        lvl_q <= LvlW'(lvl_q + 1'b1);
      end else if (do_pop && !do_push) begin
        lvl_q <= LvlW'(lvl_q - 1'b1);
      end
    end
  end

endmodule
`default_nettype wire

>>> design/acsp_back.sv
// Back end: keeps the parameter store and emits result words from commands.
`default_nettype none
module acsp_back #(
  parameter int unsigned MAX_PARAMS = acsp_pkg::MaxParamsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  acsp_pkg::cmd_t   cmd_i,
  input  wire logic        cmd_empty_i,
  output logic             cmd_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic             kind_o,
  output logic [7:0]       code_byte_o,
  output logic             private_mark_o,
  output logic [2:0]       param_index_o,
  output logic [15:0]      param_value_o,
  output logic [3:0]       param_total_o,
  output logic             last_o
);
  import acsp_pkg::*;

  localparam int unsigned IdxW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

  back_state_e     state_q, state_d;
  logic [15:0]     store_q [MAX_PARAMS];
  logic [IdxW-1:0] wr_ptr_q;
  logic [IdxW-1:0] rd_idx;
  logic [2:0]      k_q;
  logic [7:0]      run_code_q;
  logic            run_priv_q;
  logic [3:0]      run_total_q;
  logic [3:0]      run_n_q;
  logic            out_valid_q;
  logic            out_free;
  logic            run_last;
  logic            do_write;
  logic            load_char;
  logic            load_param;
  logic            start_run;

  assign out_free = !out_valid_q || pop_i;
  assign empty_o = !out_valid_q;
  assign rd_idx = IdxW'(k_q);
  assign run_last = ({1'b0, k_q} + 4'd1) == run_n_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BACK_IDLE: begin
        if (!cmd_empty_i && cmd_i.op == OP_RUN) begin
          state_d = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (out_free && run_last) begin
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    do_write = 1'b0;
    load_char = 1'b0;
    load_param = 1'b0;
    start_run = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            OP_CHAR: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                load_char = 1'b1;
              end
            end
            OP_STORE: begin
              cmd_pop_o = 1'b1;
              do_write = 1'b1;
            end
            OP_RUN: begin
              cmd_pop_o = 1'b1;
              do_write = cmd_i.store_en;
              start_run = 1'b1;
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      BACK_RUN: begin
        load_param = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      store_q[wr_ptr_q] <= cmd_i.value;
    end
    if (start_run) begin
      run_code_q <= cmd_i.code;
      run_priv_q <= cmd_i.priv;
      run_total_q <= cmd_i.total;
      run_n_q <= cmd_i.count;
    end
    if (load_char) begin
      kind_o <= 1'b0;
      code_byte_o <= cmd_i.code;
      private_mark_o <= 1'b0;
      param_index_o <= '0;
      param_value_o <= '0;
      param_total_o <= '0;
      last_o <= 1'b1;
    end else if (load_param) begin
      kind_o <= 1'b1;
      code_byte_o <= run_code_q;
      private_mark_o <= run_priv_q;
      param_index_o <= k_q;
      param_value_o <= store_q[rd_idx];
      param_total_o <= run_total_q;
      last_o <= run_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
      wr_ptr_q <= '0;
      k_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_run) begin
        wr_ptr_q <= '0;
        k_q <= '0;
      end else begin
        if (do_write) begin
          wr_ptr_q <= IdxW'(wr_ptr_q + 1'b1);
        end
        if (load_param) begin
          k_q <= 3'(k_q + 1'b1);
        end
      end
      if (load_char || load_param) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BACK_RUN) |-> (run_n_q != 4'd0 && {1'b0, k_q} < run_n_q))
    else $error("Run counter is outside the run length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !kind_o) |-> (last_o && param_total_o == 4'd0))
    else $error("A plain character word is not a complete run.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BACK_RUN) |-> !cmd_pop_o)
    else $error("A command was taken while a run is still being emitted.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_param && run_last) |=> (state_q == BACK_IDLE))
    else $error("The run did not end after its last word.");

endmodule
`default_nettype wire

>>> design/ansi_csi_sequence_parser.sv
// Top level of the CSI sequence parser: front end, command queue and back end.
//
// The block takes one byte per cycle into its front end whenever the two-entry
// command queue has room, so plain characters, '?', digits and ';' all enter at
// that rate on the input side. The back end takes each command from the queue
// in turn; a plain character is loaded into the output register as one result
// word as it is taken, so its word passes through the queue entry and then the
// output register, while each stored ';' is written into the parameter store
// and a sequence's final byte then emits one result word per stored parameter,
// one per cycle while the output register is free, for at most eight words.
// The output register lets a waiting result sit while the next byte enters.
`default_nettype none
module ansi_csi_sequence_parser #(
  parameter int unsigned MAX_PARAMS = acsp_pkg::MaxParamsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic             kind_o,
  output logic [7:0]       code_byte_o,
  output logic             private_mark_o,
  output logic [2:0]       param_index_o,
  output logic [15:0]      param_value_o,
  output logic [3:0]       param_total_o,
  output logic             last_o
);
  import acsp_pkg::*;

  logic accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign accept = push && !full;

  acsp_front #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  acsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head),
    .empty_o (cmd_empty)
  );

  acsp_back #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_head),
    .cmd_empty_i    (cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .code_byte_o    (code_byte_o),
    .private_mark_o (private_mark_o),
    .param_index_o  (param_index_o),
    .param_value_o  (param_value_o),
    .param_total_o  (param_total_o),
    .last_o         (last_o)
  );

endmodule
`default_nettype wire
